// ===== hw/rtl/fss_pkg.sv =====
// fss_pkg: shared types, signature table and constants for the file signature scanner.
// No dependencies; imported by every module of the block.
package fss_pkg;

	// Signature table: headers first in table order, then footers (priority order)
	localparam int SigCount = 15;
	localparam int SigMax   = 8;
	localparam int SelW     = 4;

	localparam logic KindHeader = 1'b0;
	localparam logic KindFooter = 1'b1;

	// Bytes packed so that byte [0] is the byte that ends the match,
	// byte [k] the one k positions earlier in the stream.
	localparam logic [SigMax-1:0][7:0] SigBytes [SigCount] = '{
		64'h0000_0000_2550_4446,  // pdf header
		64'h0000_0000_00FF_D8FF,  // jpg header
		64'h0000_0000_8950_4E47,  // png header
		64'h0000_4749_4638_3761,  // gif87a header
		64'h0000_4749_4638_3961,  // gif89a header
		64'h0000_0000_0049_4433,  // mp3 id3 header
		64'h0000_0000_0000_FFFB,  // mp3 frame header
		64'h6674_7970_6973_6F6D,  // mp4 isom header
		64'h6674_7970_6D70_3432,  // mp4 mp42 header
		64'h0000_0000_504B_0304,  // docx header
		64'h0000_0000_504B_0304,  // zip header
		64'h0000_0025_2545_4F46,  // pdf footer
		64'h0000_0000_0000_FFD9,  // jpg footer
		64'h4945_4E44_AE42_6082,  // png footer
		64'h0000_0000_0000_003B   // gif footer
	};

	localparam logic [3:0] SigLen [SigCount] = '{
		4'd4, 4'd3, 4'd4, 4'd6, 4'd6, 4'd3, 4'd2, 4'd8, 4'd8, 4'd4, 4'd4,
		4'd5, 4'd2, 4'd8, 4'd1
	};

	localparam logic SigKind [SigCount] = '{
		KindHeader, KindHeader, KindHeader, KindHeader, KindHeader, KindHeader,
		KindHeader, KindHeader, KindHeader, KindHeader, KindHeader,
		KindFooter, KindFooter, KindFooter, KindFooter
	};

	localparam logic [3:0] SigIdx [SigCount] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10,
		4'd0, 4'd1, 4'd2, 4'd3
	};

	// Highest index legal for each kind
	localparam logic [3:0] MaxHeaderIdx = 4'd10;
	localparam logic [3:0] MaxFooterIdx = 4'd3;

	// Output transaction layout
	localparam int StartW  = 48;
	localparam int OutTdW  = 56;
	localparam int OutPadW = OutTdW - StartW - 4;

	// Match queue between front and back
	localparam int QDepth = 4;
	localparam int QPtrW  = 2;

	typedef struct packed {
		logic              kind;
		logic [3:0]        idx;
		logic [StartW-1:0] start;
	} match_event_t;

	// All matches caused by one byte (one or two)
	typedef struct packed {
		logic         two;
		match_event_t ev0;
		match_event_t ev1;
	} match_entry_t;

endpackage

// ===== hw/rtl/fss_front.sv =====
// fss_front: byte window, fill count and offset counter; matches each byte against
// the signature table and pushes the matches it causes into the queue. Uses fss_pkg.
module fss_front #(
	parameter int WINDOW_BYTES = 8,
	parameter int OFFSET_BITS  = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [7:0]            in_byte,
	input  logic                  in_restart,
	output logic                  in_ready,
	input  logic                  q_full,
	output logic                  push,
	output fss_pkg::match_entry_t push_entry
);
	import fss_pkg::*;

	localparam int Hist  = WINDOW_BYTES - 1;
	localparam int FillW = $clog2(WINDOW_BYTES);
	localparam int AvW   = FillW + 1;

	logic [7:0]             win_q [Hist];
	logic [FillW-1:0]       fill_q;
	logic [OFFSET_BITS-1:0] offset_q;

	logic [7:0]             cur [Hist+1];
	logic [AvW-1:0]         avail;
	logic [FillW-1:0]       fill_base;
	logic [OFFSET_BITS-1:0] offset_cur;
	logic [SigCount-1:0]    hit;
	logic                   found0, found1;
	logic [SelW-1:0]        sel0, sel1;
	logic [OFFSET_BITS-1:0] st0, st1;
	logic                   accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Current byte plus history; restart drops the history for this byte
	always_comb begin
		cur[0] = in_byte;
		for (int k = 1; k <= Hist; k++) begin
			cur[k] = win_q[k-1];
		end
		fill_base  = in_restart ? '0 : fill_q;
		avail      = AvW'(fill_base) + AvW'(1);
		offset_cur = in_restart ? '0 : offset_q;
	end

	// Compare every signature against the bytes ending here
	always_comb begin
		for (int s = 0; s < SigCount; s++) begin
			hit[s] = (AvW'(SigLen[s]) <= avail);
			for (int j = 0; j < SigMax; j++) begin
				if ((4'(j) < SigLen[s]) && (cur[j] != SigBytes[s][j])) begin
					hit[s] = 1'b0;
				end
			end
		end
	end

	// First two hits in priority order
	always_comb begin
		found0 = 1'b0;
		found1 = 1'b0;
		sel0   = '0;
		sel1   = '0;
		for (int s = 0; s < SigCount; s++) begin
			if (hit[s]) begin
				if (!found0) begin
					found0 = 1'b1;
					sel0   = SelW'(s);
				end else if (!found1) begin
					found1 = 1'b1;
					sel1   = SelW'(s);
				end
			end
		end
	end

	// Start offsets: offset of this byte minus length plus one
	always_comb begin
		st0 = offset_cur - OFFSET_BITS'(SigLen[sel0] - 4'd1);
		st1 = offset_cur - OFFSET_BITS'(SigLen[sel1] - 4'd1);
		push_entry.two       = found1;
		push_entry.ev0.kind  = SigKind[sel0];
		push_entry.ev0.idx   = SigIdx[sel0];
		push_entry.ev0.start = StartW'(st0);
		push_entry.ev1.kind  = SigKind[sel1];
		push_entry.ev1.idx   = SigIdx[sel1];
		push_entry.ev1.start = StartW'(st1);
	end

	assign push = accept && found0;

	// Fill count and offset counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			offset_q <= '0;
		end else if (accept) begin
			fill_q   <= (fill_base == FillW'(Hist)) ? fill_base : fill_base + FillW'(1);
			offset_q <= offset_cur + OFFSET_BITS'(1);
		end
	end

	// History shift line
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[0] <= in_byte;
			for (int k = 1; k < Hist; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

endmodule

// ===== hw/rtl/fss_queue.sv =====
// fss_queue: short FIFO of per-byte match entries between front and back.
// Uses fss_pkg for the entry type and depth.
module fss_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fss_pkg::match_entry_t push_entry,
	input  logic                  pop,
	output fss_pkg::match_entry_t head,
	output logic                  empty,
	output logic                  full
);
	import fss_pkg::*;

	match_entry_t     mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPtrW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPtrW+1)'(QDepth));
	assign head  = mem_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			if (push && !pop)      cnt_q <= cnt_q + (QPtrW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QPtrW+1)'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ===== hw/rtl/fss_emit.sv =====
// fss_emit: output register; splits each queued entry into one or two output
// transactions and marks the last one. Uses fss_pkg.
module fss_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fss_pkg::match_entry_t      head,
	input  logic                       empty,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [fss_pkg::OutTdW-1:0] m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast
);
	import fss_pkg::*;

	logic         valid_q;
	logic         sel_q;     // second event of the head entry is next
	match_event_t ev_q;
	logic         last_q;
	logic         load;

	assign load = !valid_q || m_tready;
	assign pop  = load && (sel_q || (!empty && !head.two));

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			if (sel_q) begin
				valid_q <= 1'b1;
				sel_q   <= 1'b0;
			end else if (!empty) begin
				valid_q <= 1'b1;
				sel_q   <= head.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			ev_q   <= sel_q ? head.ev1 : head.ev0;
			last_q <= sel_q || !head.two;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {OutPadW'(0), ev_q.start, ev_q.idx};
	assign m_tuser  = ev_q.kind;
	assign m_tlast  = last_q;

endmodule

// ===== hw/rtl/file_signature_scanner.sv =====
// file_signature_scanner: top level; front matcher, match queue and output stage.
// Depends on fss_pkg, fss_front, fss_queue and fss_emit.
//
// Takes one raw disk byte per cycle and reports every header or footer magic number
// (pdf, jpeg, png, gif, mp3, mp4, docx, zip) that ends on that byte, with its kind,
// table index and start offset. A byte is accepted every cycle while the four-entry
// match queue has room; each byte that matches costs one queue entry. A byte ending
// two matches (docx and zip share a header) gives two output transactions in turn, so
// the output port, at one transaction per cycle while m_tready is high, sets the rate
// only for runs of such bytes. Results pass the match queue, then the output register.
// s_tuser high restarts the window and offset at this byte (offset 0).
module file_signature_scanner #(
	parameter int WINDOW_BYTES = 8,
	parameter int OFFSET_BITS  = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] data_byte
	input  logic                       s_tuser,   // [0] restart
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [fss_pkg::OutTdW-1:0] m_tdata,   // [3:0] signature_index, [51:4] start_offset
	output logic                       m_tuser,   // [0] match_kind
	output logic                       m_tlast    // last_of_run
);
	import fss_pkg::*;

	logic         q_push, q_pop, q_empty, q_full;
	match_entry_t q_in, q_head;

	fss_front #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_restart(s_tuser),
		.in_ready  (s_tready),
		.q_full    (q_full),
		.push      (q_push),
		.push_entry(q_in)
	);

	fss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	fss_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.empty   (q_empty),
		.pop     (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ===== hw/rtl/fss_checker.sv =====
// fss_checker: port-level assertions for file_signature_scanner, bound to the top.
// Depends on fss_pkg and file_signature_scanner.
module fss_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [fss_pkg::OutTdW-1:0] m_tdata,
	input logic                       m_tuser,
	input logic                       m_tlast
);
	import fss_pkg::*;

	// No result out of reset: every edge in reset leaves the output idle
	a_idle_in_reset: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("m_tvalid high during reset");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// Index within the table of its kind, pad bits zero
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((!m_tuser && m_tdata[3:0] <= MaxHeaderIdx)
			|| (m_tuser && m_tdata[3:0] <= MaxFooterIdx))
			&& (m_tdata[OutTdW-1:StartW+4] == '0))
		else $error("signature index out of range or pad bits set");

	// First of a double match is followed at once by its last
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
		else $error("second event of a byte did not follow");

	// A non-last event is always a header (double matches are header pairs)
	a_pair_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !m_tuser)
		else $error("footer event not marked last");

endmodule

bind file_signature_scanner fss_checker u_fss_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

// ===== test/file_signature_scanner_tb.sv =====
`timescale 1ns / 100ps
// file_signature_scanner_tb: self-checking bench for the file signature scanner.
// Depends on fss_pkg and file_signature_scanner; drives byte streams with random gaps
// and checks every match transaction against a scoreboard with its own matcher.
module file_signature_scanner_tb;
	import fss_pkg::*;

	// Signature patterns, written as in the stream: the last byte sits in the low bits
	localparam int PatCount = 15;
	localparam int HeadCount = 11;
	localparam int HistDepth = 7;

	typedef enum int {
		PatPdf, PatJpg, PatPng, PatGif87, PatGif89, PatId3, PatMp3Frame,
		PatIsom, PatMp42, PatDocx, PatZip,
		PatPdfEnd, PatJpgEnd, PatPngEnd, PatGifEnd
	} pattern_e;

	localparam logic [63:0] ScanPat [PatCount] = '{
		64'h25504446, 64'hFFD8FF, 64'h89504E47, 64'h474946383761, 64'h474946383961,
		64'h494433, 64'hFFFB, 64'h6674797069736F6D, 64'h667479706D703432,
		64'h504B0304, 64'h504B0304,
		64'h2525454F46, 64'hFFD9, 64'h49454E44AE426082, 64'h3B
	};
	localparam int ScanLen [PatCount] = '{4, 3, 4, 6, 6, 3, 2, 8, 8, 4, 4, 5, 2, 8, 1};

	typedef struct packed {
		logic              kind;
		logic [3:0]        idx;
		logic [StartW-1:0] start;
		logic              last;
	} scan_event_t;

	// Byte j of a pattern in stream order
	function automatic logic [7:0] pat_byte(int sel, int j);
		return ScanPat[sel][8*(ScanLen[sel]-1-j) +: 8];
	endfunction

	class match_scoreboard;
		logic [7:0]        hist [HistDepth];
		int                fill;
		logic [StartW-1:0] next_off;
		scan_event_t       expected_q[$];
		int                errors;

		function new();
			clear_window();
			errors = 0;
		endfunction

		function void clear_window();
			foreach (hist[k]) hist[k] = 8'h00;
			fill = 0;
			next_off = '0;
		endfunction

		// Pattern sel ends on byte b, with every byte seen since the last restart
		function bit pattern_hit(int sel, logic [7:0] b);
			logic [7:0] got;
			if (ScanLen[sel] > fill + 1) return 1'b0;
			for (int k = 0; k < ScanLen[sel]; k++) begin
				got = (k == 0) ? b : hist[k-1];
				if (got != ScanPat[sel][8*k +: 8]) return 1'b0;
			end
			return 1'b1;
		endfunction

		// Accepted input transaction: queue the matches it ends
		function void note_byte(logic [7:0] b, logic rs);
			scan_event_t ev;
			int n;
			n = 0;
			if (rs) clear_window();
			for (int i = 0; i < PatCount && n < 2; i++) begin
				if (pattern_hit(i, b)) begin
					ev.kind  = (i >= HeadCount) ? KindFooter : KindHeader;
					ev.idx   = (i >= HeadCount) ? 4'(i - HeadCount) : 4'(i);
					ev.start = next_off - StartW'(ScanLen[i] - 1);
					ev.last  = 1'b0;
					expected_q.push_back(ev);
					n++;
				end
			end
			if (n > 0) expected_q[expected_q.size()-1].last = 1'b1;
			for (int k = HistDepth - 1; k > 0; k--) hist[k] = hist[k-1];
			hist[0] = b;
			if (fill < HistDepth) fill++;
			next_off = next_off + 1'b1;
		endfunction

		// Accepted output transaction against the oldest expected match
		function void check_result(logic kind, logic [3:0] idx, logic [StartW-1:0] start,
				logic last);
			scan_event_t ev;
			if (expected_q.size() == 0) begin
				$error("unexpected match: kind %0d index %0d start %0h", kind, idx, start);
				errors++;
				return;
			end
			ev = expected_q.pop_front();
			if (ev.kind !== kind) begin
				$error("match_kind: expected %0d, actual %0d", ev.kind, kind);
				errors++;
			end
			if (ev.idx !== idx) begin
				$error("signature_index: expected %0d, actual %0d", ev.idx, idx);
				errors++;
			end
			if (ev.start !== start) begin
				$error("start_offset: expected %0h, actual %0h", ev.start, start);
				errors++;
			end
			if (ev.last !== last) begin
				$error("last_of_run: expected %0d, actual %0d", ev.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = 8'h00;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OutTdW-1:0] m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	match_scoreboard sb;
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;
	int sink_hold = 0;
	int sent = 0;

	file_signature_scanner u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sink: random back pressure
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!sink_steady) sink_hold = idle_len();
		end
	end

	// Monitor: every accepted match transaction goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[3:0], m_tdata[StartW+3:4], m_tlast);
	end

	// One input transaction, after an optional gap
	task automatic push_byte(input logic [7:0] b, input logic rs);
		int gap;
		gap = src_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= rs;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b, rs);
		sent++;
	endtask

	// Bytes first .. first+count-1 of a pattern, restart on the first one if asked
	task automatic push_pattern(input int sel, input int first, input int count,
			input logic rs_first);
		for (int j = first; j < first + count; j++)
			push_byte(pat_byte(sel, j), rs_first && (j == first));
	endtask

	initial begin
		int choice;
		int sel;
		int cut;
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Directed: gif footer at offset zero, byte extremes, jpg footer
		push_byte(8'h3B, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hD9, 1'b0);
		// longest header right after a restart fills the whole window
		push_pattern(PatIsom, 0, 8, 1'b1);
		// docx and zip end on the same byte
		push_pattern(PatDocx, 0, 4, 1'b0);
		// restart inside a header cuts its history
		push_pattern(PatZip, 0, 2, 1'b0);
		push_pattern(PatZip, 2, 2, 1'b1);
		push_pattern(PatPdfEnd, 0, 5, 1'b0);
		// jpg header, then its last byte starts an mp3 frame header
		push_pattern(PatJpg, 0, 3, 1'b0);
		push_byte(8'hFB, 1'b0);

		// Random: mostly whole signatures inside noise
		while (sent < 445) begin
			if ($urandom_range(0, 19) == 0) src_steady = ~src_steady;
			if ($urandom_range(0, 19) == 0) sink_steady = ~sink_steady;
			choice = $urandom_range(0, 99);
			sel = $urandom_range(0, PatCount - 1);
			if (choice < 50 || ScanLen[sel] < 2) begin
				push_pattern(sel, 0, ScanLen[sel], $urandom_range(0, 6) == 0);
			end else if (choice < 65) begin
				// broken signature: prefix then a random byte
				cut = $urandom_range(1, ScanLen[sel] - 1);
				push_pattern(sel, 0, cut, 1'b0);
				push_byte(8'($urandom), 1'b0);
			end else if (choice < 75) begin
				// restart lands inside a signature
				cut = $urandom_range(1, ScanLen[sel] - 1);
				push_pattern(sel, 0, cut, 1'b0);
				push_pattern(sel, cut, ScanLen[sel] - cut, 1'b1);
			end else begin
				repeat ($urandom_range(1, 8))
					push_byte(8'($urandom), $urandom_range(0, 15) == 0);
			end
		end
		s_tvalid <= 1'b0;
		sink_steady = 1'b0;

		// Drain, then wait a while for anything unexpected
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[file_signature_scanner] OK");
		end else begin
			$display("[file_signature_scanner] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("[file_signature_scanner] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/fss_pkg.sv
hw/rtl/fss_front.sv
hw/rtl/fss_queue.sv
hw/rtl/fss_emit.sv
hw/rtl/file_signature_scanner.sv
hw/rtl/fss_checker.sv
test/file_signature_scanner_tb.sv
